[hw/rtl/polyline_normal_averager_top_macros.svh]
`ifndef POLYLINE_NORMAL_AVERAGER_TOP_MACROS_SVH
`define POLYLINE_NORMAL_AVERAGER_TOP_MACROS_SVH

// Assertion helpers; expect clk and arst_n in scope.
`define PNA_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define PNA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define PNA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/pna_pkg.sv]
package pna_pkg;

	localparam int COORD_WIDTH      = 32;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int INDEX_WIDTH      = 16;

	// magnitudes are brought below 2^NORM_GUARD before squaring
	localparam int NORM_GUARD  = 30;
	localparam int NORMAL_W    = 16;
	localparam int INDEX_OUT_W = 16;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_ZERO_LEN,
		STAT_SINGLE
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAG,
		ST_NORM,
		ST_SQ,
		ST_SQRT,
		ST_DIVINIT,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		EM_SINGLE,
		EM_AVG,
		EM_TAIL0,
		EM_TAIL1
	} emit_t;

endpackage

[hw/rtl/pna_ifs.sv]
interface pna_point_if #(
	parameter int CoordWidth = pna_pkg::COORD_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [CoordWidth-1:0] coord_x;
	logic signed [CoordWidth-1:0] coord_y;
	logic signed [CoordWidth-1:0] coord_z;
	logic                         last_point;

	modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
	modport sink (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

interface pna_normal_if;
	import pna_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [NORMAL_W-1:0]    normal_x;
	logic signed [NORMAL_W-1:0]    normal_y;
	logic        [INDEX_OUT_W-1:0] point_index;
	logic                          last_normal;
	status_t                       status;

	modport source (output valid, normal_x, normal_y, point_index, last_normal, status,
		input ready);
	modport sink (input valid, normal_x, normal_y, point_index, last_normal, status,
		output ready);
endinterface

[hw/rtl/polyline_normal_averager_top.sv]
// Channel   Dir  Beat
// points    in   coord_x, coord_y, coord_z (signed Q16.16), last_point
// normals   out  normal_x, normal_y (signed Q1.14), point_index, last_normal, status
//
// A point after the first passes through magnitude, normalize, 4 square,
// 31 root and NORMAL_FRAC_BITS+1 divide steps (both components at once).
// A zero-length segment skips from magnitude straight to sign.
// arst_n clears control state, the previous point, held normal and count.
// A stalled normals channel parks the block in emit; the last beat waits in the output register.
`include "polyline_normal_averager_top_macros.svh"

module polyline_normal_averager_top #(
	parameter int COORD_WIDTH      = pna_pkg::COORD_WIDTH,
	parameter int NORMAL_FRAC_BITS = pna_pkg::NORMAL_FRAC_BITS,
	parameter int INDEX_WIDTH      = pna_pkg::INDEX_WIDTH
) (
	input logic          clk,
	input logic          arst_n,
	pna_point_if.sink    points,
	pna_normal_if.source normals
);
	import pna_pkg::*;

	localparam int Guard  = NORM_GUARD;
	localparam int Dw     = COORD_WIDTH + 1;
	localparam int Mw     = (Dw > Guard) ? Dw : Guard + 1;
	localparam int SumW   = 2 * Guard + 2;
	localparam int RootW  = Guard + 1;
	localparam int RemW   = Guard + 3;
	localparam int Nfb    = NORMAL_FRAC_BITS;
	localparam int NumW   = Guard + Nfb + 1;
	localparam int QW     = Nfb + 1;
	localparam int DrW    = Guard + 1;
	localparam int NW     = Nfb + 2;
	localparam int PsW    = INDEX_WIDTH + 1;
	localparam int SqrtSteps = SumW / 2;
	localparam int DivSteps  = QW;
	localparam int CntMax = (SqrtSteps > DivSteps) ? SqrtSteps : DivSteps;
	localparam int CntW   = $clog2(CntMax + 1);

	localparam logic [PsW-1:0]  IdxMax = {1'b0, {INDEX_WIDTH{1'b1}}};
	localparam logic [PsW-1:0]  PsMax  = IdxMax + PsW'(2);
	localparam logic [QW-1:0]   QOne   = {1'b1, {Nfb{1'b0}}};
	localparam logic [CntW-1:0] SqLast = CntW'(3);

	state_t state_q, state_d;
	emit_t  sel_q;

	logic in_take, out_free, out_load, emit_last;

	logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic [PsW-1:0]  ps_q;
	logic            last_q;
	logic [Dw-1:0]   dx_q, dy_q, dz_q;
	logic [Mw-1:0]   ax_q, ay_q, az_q;
	logic            neg_nx_q, neg_ny_q;
	logic            d_zero, norm_big;
	logic [2*Guard-1:0] prod_q;
	logic [SumW-1:0] rad_q;
	logic [RemW-1:0] rem_q;
	logic [RootW-1:0] root_q;
	logic [CntW-1:0] cnt_q;
	logic [NumW-1:0] num_x, num_y;
	logic [DrW-1:0]  drem_x_q, drem_y_q;
	logic [QW-1:0]   nlow_x_q, nlow_y_q;
	logic [QW-1:0]   q_x_q, q_y_q;
	status_t         st_q, held_st_q;
	logic signed [NW-1:0] raw_x_q, raw_y_q, raw_x_d, raw_y_d;
	logic signed [NW-1:0] held_x_q, held_y_q;

	// square root step
	logic [RemW+1:0] sq_cur, sq_trial;
	logic            sq_ge;
	// divide step
	logic [DrW:0]    dv_cur_x, dv_cur_y, dv_len;
	logic            dv_ge_x, dv_ge_y;
	// emit datapath
	logic signed [NW:0]   avg_sum_x, avg_sum_y;
	logic signed [NW-1:0] em_x, em_y;
	logic [PsW-1:0]       em_back, em_idx_raw, em_idx;
	logic                 em_last;
	status_t              em_st;
	logic [QW-1:0]        qc_x, qc_y;

	logic signed [NORMAL_W-1:0]    out_nx_q, out_ny_q;
	logic        [INDEX_OUT_W-1:0] out_idx_q;
	logic                          out_last_q, out_valid_q;
	status_t                       out_st_q;

	assign in_take   = points.valid && points.ready;
	assign out_free  = !out_valid_q || normals.ready;
	assign d_zero    = (dx_q == '0) && (dy_q == '0) && (dz_q == '0);
	assign norm_big  = (|ax_q[Mw-1:Guard]) || (|ay_q[Mw-1:Guard]) || (|az_q[Mw-1:Guard]);
	assign emit_last = (sel_q == EM_SINGLE) || (sel_q == EM_TAIL1)
		|| ((sel_q == EM_AVG) && !last_q);

	assign points.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					if (ps_q != '0) begin
						state_d = ST_MAG;
					end else if (points.last_point) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_MAG: state_d = d_zero ? ST_SIGN : ST_NORM;
			ST_NORM: begin
				if (!norm_big) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				if (cnt_q == SqLast) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (cnt_q == '0) begin
					state_d = ST_DIVINIT;
				end
			end
			ST_DIVINIT: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: state_d = ((ps_q >= PsW'(3)) || last_q) ? ST_EMIT : ST_IDLE;
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			prev_z_q  <= '0;
			ps_q      <= '0;
			last_q    <= 1'b0;
			sel_q     <= EM_SINGLE;
			held_x_q  <= '0;
			held_y_q  <= '0;
			held_st_q <= STAT_OK;
		end else begin
			if (in_take) begin
				prev_x_q <= points.coord_x;
				prev_y_q <= points.coord_y;
				prev_z_q <= points.coord_z;
				last_q   <= points.last_point;
				if (ps_q == '0) begin
					sel_q <= EM_SINGLE;
					if (!points.last_point) begin
						ps_q <= PsW'(1);
					end
				end else if (ps_q < PsMax) begin
					ps_q <= ps_q + PsW'(1);
				end
			end
			if (state_q == ST_SIGN) begin
				if (ps_q >= PsW'(3)) begin
					sel_q <= EM_AVG;
				end else if (last_q) begin
					sel_q <= EM_TAIL0;
				end else begin
					held_x_q  <= raw_x_d;
					held_y_q  <= raw_y_d;
					held_st_q <= st_q;
				end
			end
			if (out_load) begin
				unique case (sel_q)
					EM_AVG:   sel_q <= EM_TAIL0;
					EM_TAIL0: sel_q <= EM_TAIL1;
					EM_TAIL1: sel_q <= EM_TAIL1;
					EM_SINGLE: sel_q <= EM_SINGLE;
					default:  sel_q <= EM_SINGLE;
				endcase
				if (emit_last) begin
					if (sel_q != EM_SINGLE) begin
						held_x_q  <= raw_x_q;
						held_y_q  <= raw_y_q;
						held_st_q <= st_q;
					end
					if (last_q) begin
						ps_q <= '0;
					end
				end
			end
		end
	end

	assign sq_cur   = {rem_q, rad_q[SumW-1 -: 2]};
	assign sq_trial = (RemW+2)'({root_q, 2'b01});
	assign sq_ge    = (sq_cur >= sq_trial);

	assign num_x  = NumW'({ay_q[Guard-1:0], {Nfb{1'b0}}}) + NumW'(root_q >> 1);
	assign num_y  = NumW'({ax_q[Guard-1:0], {Nfb{1'b0}}}) + NumW'(root_q >> 1);
	assign dv_len = (DrW+1)'(root_q);
	assign dv_cur_x = {drem_x_q, nlow_x_q[QW-1]};
	assign dv_cur_y = {drem_y_q, nlow_y_q[QW-1]};
	assign dv_ge_x  = (dv_cur_x >= dv_len);
	assign dv_ge_y  = (dv_cur_y >= dv_len);

	assign qc_x    = (q_x_q > QOne) ? QOne : q_x_q;
	assign qc_y    = (q_y_q > QOne) ? QOne : q_y_q;
	assign raw_x_d = neg_nx_q ? -$signed({1'b0, qc_x}) : $signed({1'b0, qc_x});
	assign raw_y_d = neg_ny_q ? -$signed({1'b0, qc_y}) : $signed({1'b0, qc_y});

	// serial datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				dx_q <= {points.coord_x[COORD_WIDTH-1], points.coord_x}
					- {prev_x_q[COORD_WIDTH-1], prev_x_q};
				dy_q <= {points.coord_y[COORD_WIDTH-1], points.coord_y}
					- {prev_y_q[COORD_WIDTH-1], prev_y_q};
				dz_q <= {points.coord_z[COORD_WIDTH-1], points.coord_z}
					- {prev_z_q[COORD_WIDTH-1], prev_z_q};
			end
			ST_MAG: begin
				ax_q     <= Mw'(dx_q[Dw-1] ? (~dx_q + Dw'(1)) : dx_q);
				ay_q     <= Mw'(dy_q[Dw-1] ? (~dy_q + Dw'(1)) : dy_q);
				az_q     <= Mw'(dz_q[Dw-1] ? (~dz_q + Dw'(1)) : dz_q);
				neg_nx_q <= !dy_q[Dw-1];
				neg_ny_q <= dx_q[Dw-1];
				st_q     <= d_zero ? STAT_ZERO_LEN : STAT_OK;
				q_x_q    <= '0;
				q_y_q    <= '0;
			end
			ST_NORM: begin
				if (norm_big) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
					az_q <= az_q >> 1;
				end else begin
					cnt_q <= '0;
					rad_q <= '0;
				end
			end
			ST_SQ: begin
				// three squares through one multiplier, magnitudes rotate back in place
				prod_q <= ax_q[Guard-1:0] * ax_q[Guard-1:0];
				if (cnt_q != SqLast) begin
					ax_q <= ay_q;
					ay_q <= az_q;
					az_q <= ax_q;
				end
				if (cnt_q != '0) begin
					rad_q <= rad_q + SumW'(prod_q);
				end
				if (cnt_q == SqLast) begin
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= CntW'(SqrtSteps - 1);
				end else begin
					cnt_q <= cnt_q + CntW'(1);
				end
			end
			ST_SQRT: begin
				rad_q  <= rad_q << 2;
				rem_q  <= sq_ge ? RemW'(sq_cur - sq_trial) : RemW'(sq_cur);
				root_q <= {root_q[RootW-2:0], sq_ge};
				cnt_q  <= cnt_q - CntW'(1);
			end
			ST_DIVINIT: begin
				drem_x_q <= DrW'(num_x[NumW-1:QW]);
				drem_y_q <= DrW'(num_y[NumW-1:QW]);
				nlow_x_q <= num_x[QW-1:0];
				nlow_y_q <= num_y[QW-1:0];
				cnt_q    <= CntW'(DivSteps - 1);
			end
			ST_DIV: begin
				drem_x_q <= dv_ge_x ? DrW'(dv_cur_x - dv_len) : DrW'(dv_cur_x);
				drem_y_q <= dv_ge_y ? DrW'(dv_cur_y - dv_len) : DrW'(dv_cur_y);
				nlow_x_q <= nlow_x_q << 1;
				nlow_y_q <= nlow_y_q << 1;
				q_x_q    <= {q_x_q[QW-2:0], dv_ge_x};
				q_y_q    <= {q_y_q[QW-2:0], dv_ge_y};
				cnt_q    <= cnt_q - CntW'(1);
			end
			ST_SIGN: begin
				raw_x_q <= raw_x_d;
				raw_y_q <= raw_y_d;
			end
			ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	assign avg_sum_x = $signed({held_x_q[NW-1], held_x_q}) + $signed({raw_x_q[NW-1], raw_x_q})
		+ $signed((NW+1)'(1));
	assign avg_sum_y = $signed({held_y_q[NW-1], held_y_q}) + $signed({raw_y_q[NW-1], raw_y_q})
		+ $signed((NW+1)'(1));

	always_comb begin
		em_x    = raw_x_q;
		em_y    = raw_y_q;
		em_back = PsW'(1);
		em_last = 1'b0;
		em_st   = st_q;
		unique case (sel_q)
			EM_SINGLE: begin
				em_x    = '0;
				em_y    = '0;
				em_back = ps_q;
				em_last = 1'b1;
				em_st   = STAT_SINGLE;
			end
			EM_AVG: begin
				em_x    = avg_sum_x[NW:1];
				em_y    = avg_sum_y[NW:1];
				em_back = PsW'(3);
				em_st   = ((held_st_q != STAT_OK) || (st_q != STAT_OK)) ? STAT_ZERO_LEN : STAT_OK;
			end
			EM_TAIL0: em_back = PsW'(2);
			EM_TAIL1: begin
				em_back = PsW'(1);
				em_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign em_idx_raw = ps_q - em_back;
	assign em_idx     = (em_idx_raw > IdxMax) ? IdxMax : em_idx_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (normals.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_nx_q   <= NORMAL_W'(em_x);
			out_ny_q   <= NORMAL_W'(em_y);
			out_idx_q  <= INDEX_OUT_W'(em_idx);
			out_last_q <= em_last;
			out_st_q   <= em_st;
		end
	end

	assign normals.valid       = out_valid_q;
	assign normals.normal_x    = out_nx_q;
	assign normals.normal_y    = out_ny_q;
	assign normals.point_index = out_idx_q;
	assign normals.last_normal = out_last_q;
	assign normals.status      = out_st_q;

	`PNA_ASSERT_IMPL(a_div_rem_below_len, state_q == ST_DIV,
		(drem_x_q < root_q) && (drem_y_q < root_q), "divider remainder not below segment length")
	`PNA_ASSERT_IMPL(a_norm_nonzero, state_q == ST_NORM,
		(ax_q | ay_q | az_q) != '0, "zero-length segment entered normalization")
	`PNA_ASSERT_HOLDS(a_count_bound, ps_q <= PsMax, "point count past saturation")
	`PNA_ASSERT_NEXT(a_count_clear, out_load && emit_last && last_q,
		ps_q == '0, "point count not cleared after final beat")

endmodule
